/* sv/avgts_pkg.sv */
// ----------------------------------------------------------------------------
// avgts_pkg
// Shared types and constants for the averaged temperature sensor core.
// ----------------------------------------------------------------------------
package avgts_pkg;

  localparam int unsigned SAMPLE_W   = 12;
  localparam int unsigned SAMPLE_MAX = 4095;
  localparam int unsigned CAL_W      = 12;
  localparam int unsigned DEG_W      = 16;
  localparam int unsigned TEMP_W     = 16;
  localparam int unsigned CQ16_W     = 30;   // exact Celsius in units of 2^-16
  localparam int unsigned FW         = 25;   // Fahrenheit work width

  localparam logic [CAL_W-1:0] CAL_OFFSET_RST = 12'd1800;
  localparam logic [DEG_W-1:0] DEG_PER_CNT_RST = 16'd6000;

  // 30 degC in Q16
  localparam logic signed [CQ16_W-1:0] C30_Q16 = 30'sd1966080;
  // 5 * (32 << 16) / 256, folded in after the divide by 256
  localparam logic signed [FW-1:0] F32_OFS = 25'sd40960;
  // bias that keeps the divide-by-5 operand non-negative, and its quotient
  localparam logic [FW-1:0] F_BIAS  = 25'd20971520;
  localparam logic [FW-1:0] F_BIASQ = 25'd4194304;
  localparam int unsigned   FAHR_DIV = 5;
  localparam int unsigned   RECIP5_K = 25;
  localparam int unsigned   RECIP5_W = 23;
  localparam logic [RECIP5_W-1:0] RECIP5 = RECIP5_W'((2 ** RECIP5_K) / FAHR_DIV);

  localparam logic signed [FW-1:0] TEMP_MAX = 25'sd32767;
  localparam logic signed [FW-1:0] TEMP_MIN = -25'sd32768;

  typedef enum logic {
    REG_CAL_OFFSET    = 1'b0,
    REG_DEG_PER_COUNT = 1'b1
  } reg_idx_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD,
    S_UPD,
    S_DIVM,
    S_DIVC,
    S_MUL,
    S_FMUL,
    S_FCOR,
    S_PUSH
  } state_e;

  typedef struct packed {
    logic rd;
    logic upd;
    logic divm;
    logic divc;
    logic mul;
    logic fmul;
    logic fcor;
  } step_t;

  typedef struct packed {
    logic        [SAMPLE_W-1:0] avg;
    logic signed [TEMP_W-1:0]   temp_c;
    logic signed [TEMP_W-1:0]   temp_f;
  } result_t;

  function automatic logic signed [TEMP_W-1:0] sat_temp(input logic signed [FW-1:0] v);
    logic signed [TEMP_W-1:0] r;
    if (v > TEMP_MAX) begin
      r = TEMP_MAX[TEMP_W-1:0];
    end else if (v < TEMP_MIN) begin
      r = TEMP_MIN[TEMP_W-1:0];
    end else begin
      r = v[TEMP_W-1:0];
    end
    return r;
  endfunction

endpackage

/* sv/avgts_in_if.sv */
// ----------------------------------------------------------------------------
// avgts_in_if
// Input channel: one temperature / potentiometer conversion pair per beat.
// ----------------------------------------------------------------------------
interface avgts_in_if;
  logic        valid;
  logic        ready;
  logic [11:0] temp_sample;
  logic [11:0] pot_sample;

  modport source (output valid, output temp_sample, output pot_sample, input ready);
  modport sink   (input valid, input temp_sample, input pot_sample, output ready);
endinterface

/* sv/avgts_out_if.sv */
// ----------------------------------------------------------------------------
// avgts_out_if
// Result channel: average count, Celsius and Fahrenheit Q8.8, pot value.
// ----------------------------------------------------------------------------
interface avgts_out_if;
  logic               valid;
  logic               ready;
  logic        [11:0] average_count;
  logic signed [15:0] temp_c_q8;
  logic signed [15:0] temp_f_q8;
  logic        [11:0] pot_value;

  modport source (output valid, output average_count, output temp_c_q8,
                  output temp_f_q8, output pot_value, input ready);
  modport sink   (input valid, input average_count, input temp_c_q8,
                  input temp_f_q8, input pot_value, output ready);
endinterface

/* sv/avgts_ring.sv */
// ----------------------------------------------------------------------------
// avgts_ring
// Sample ring memory with read-modify-write of the running sum.
// ----------------------------------------------------------------------------
module avgts_ring import avgts_pkg::*; #(
  parameter int unsigned TAPS = 10
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  step_t                                 step_i,
  input  logic [SAMPLE_W-1:0]                   sample_i,
  output logic [$clog2(TAPS*SAMPLE_MAX+1)-1:0]  sum_o
);

  localparam int unsigned SUM_W  = $clog2(TAPS * SAMPLE_MAX + 1);
  localparam int unsigned SLOT_W = $clog2(TAPS);
  localparam int unsigned FILL_W = $clog2(TAPS + 1);

  logic [SAMPLE_W-1:0] ring_mem [TAPS];
  logic [SAMPLE_W-1:0] rdata_q;
  logic [SAMPLE_W-1:0] first_q, first_d;
  logic [SAMPLE_W-1:0] old_sample;
  logic [SLOT_W-1:0]   slot_q, slot_d;
  logic [FILL_W-1:0]   fill_q, fill_d;
  logic [SUM_W-1:0]    sum_q, sum_d, base_sum;
  logic                primed, full;

  // Memory: read in RD, written in UPD. Items are handled one at a time, so
  // the read of the next item always follows the write of this one.
  always_ff @(posedge clk_i) begin
    if (step_i.rd) begin
      rdata_q <= ring_mem[slot_q];
    end
    if (step_i.upd) begin
      ring_mem[slot_q] <= sample_i;
    end
  end

  // Slots not yet written since reset hold the first sample.
  always_comb begin
    primed     = (fill_q != '0);
    full       = (fill_q == FILL_W'(TAPS));
    old_sample = !primed ? sample_i : (full ? rdata_q : first_q);
    base_sum   = primed ? sum_q : SUM_W'(sample_i) * SUM_W'(TAPS);
    sum_d      = base_sum - SUM_W'(old_sample) + SUM_W'(sample_i);
    slot_d     = (slot_q == SLOT_W'(TAPS - 1)) ? '0 : slot_q + 1'b1;
    fill_d     = full ? fill_q : fill_q + 1'b1;
    first_d    = primed ? first_q : sample_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= '0;
      fill_q <= '0;
      sum_q  <= '0;
    end else if (step_i.upd) begin
      slot_q <= slot_d;
      fill_q <= fill_d;
      sum_q  <= sum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i.upd) begin
      first_q <= first_d;
    end
  end

  assign sum_o = sum_q;

endmodule

/* sv/avgts_calib.sv */
// ----------------------------------------------------------------------------
// avgts_calib
// Average by reciprocal multiply, linear calibration, Fahrenheit conversion.
// ----------------------------------------------------------------------------
module avgts_calib import avgts_pkg::*; #(
  parameter int unsigned TAPS = 10
) (
  input  logic                                  clk_i,
  input  step_t                                 step_i,
  input  logic [$clog2(TAPS*SAMPLE_MAX+1)-1:0]  sum_i,
  input  logic [CAL_W-1:0]                      cal_offset_i,
  input  logic [DEG_W-1:0]                      deg_per_count_i,
  output result_t                               res_o
);

  localparam int unsigned SUM_W = $clog2(TAPS * SAMPLE_MAX + 1);
  // floor(2^SUM_W / TAPS): estimate is at most one low
  localparam logic [SUM_W-1:0] RECIP = SUM_W'((2 ** SUM_W) / TAPS);

  logic        [2*SUM_W-1:0]    q_prod;
  logic        [SAMPLE_W-1:0]   q_est_q;
  logic        [SUM_W-1:0]      rem;
  logic        [SAMPLE_W-1:0]   avg_q, avg_d;
  logic signed [SAMPLE_W:0]     diff;
  logic signed [DEG_W:0]        deg_s;
  logic signed [CQ16_W-1:0]     c_q16_q, c_q16_d;
  logic signed [CQ16_W-9:0]     c_q8;
  logic signed [CQ16_W+2:0]     nine_c;
  logic signed [FW-1:0]         f_t;
  logic        [FW-1:0]         u_d, u_q;
  logic        [FW+RECIP5_W-1:0] q5_prod;
  logic        [RECIP5_W-1:0]   q5_q, q5_c;
  logic        [FW-1:0]         rem5;
  logic signed [FW-1:0]         f_q8;
  logic signed [TEMP_W-1:0]     temp_c_q, temp_f_q;

  always_comb begin
    q_prod  = (2*SUM_W)'(sum_i) * (2*SUM_W)'(RECIP);
    rem     = sum_i - SUM_W'(q_est_q) * SUM_W'(TAPS);
    avg_d   = (rem >= SUM_W'(TAPS)) ? q_est_q + 1'b1 : q_est_q;

    diff    = $signed({1'b0, avg_q}) - $signed({1'b0, cal_offset_i});
    deg_s   = $signed({1'b0, deg_per_count_i});
    c_q16_d = CQ16_W'(diff) * CQ16_W'(deg_s) + C30_Q16;

    // floor(9c/256) + 40960, then floor(./5) via biased reciprocal
    c_q8    = c_q16_q[CQ16_W-1:8];
    nine_c  = ((CQ16_W+3)'(c_q16_q) <<< 3) + (CQ16_W+3)'(c_q16_q);
    f_t     = $signed(nine_c[CQ16_W+2:8]) + F32_OFS;
    u_d     = f_t + F_BIAS;
    q5_prod = (FW+RECIP5_W)'(u_d) * (FW+RECIP5_W)'(RECIP5);

    rem5    = u_q - ((FW'(q5_q) << 2) + FW'(q5_q));
    q5_c    = (rem5 >= FW'(FAHR_DIV)) ? q5_q + 1'b1 : q5_q;
    f_q8    = $signed(FW'(q5_c) - F_BIASQ);
  end

  always_ff @(posedge clk_i) begin
    if (step_i.divm) begin
      q_est_q <= q_prod[SUM_W +: SAMPLE_W];
    end
    if (step_i.divc) begin
      avg_q <= avg_d;
    end
    if (step_i.mul) begin
      c_q16_q <= c_q16_d;
    end
    if (step_i.fmul) begin
      temp_c_q <= sat_temp(FW'(c_q8));
      u_q      <= u_d;
      q5_q     <= q5_prod[RECIP5_K +: RECIP5_W];
    end
    if (step_i.fcor) begin
      temp_f_q <= sat_temp(f_q8);
    end
  end

  assign res_o.avg    = avg_q;
  assign res_o.temp_c = temp_c_q;
  assign res_o.temp_f = temp_f_q;

endmodule

/* sv/averaged_temperature_sensor_core.sv */
// ----------------------------------------------------------------------------
// averaged_temperature_sensor_core
// Items are handled one at a time, in the steps of the step sequencer (idle
// cycle that takes the beat, ring read, ring write, two-step divide,
// calibration multiply, two-step Fahrenheit divide, result push); no new beat
// is taken before the push. A stalled result holds the push step.
// Reset: async active low; ring counts and sum clear, registers take their
// calibration defaults, the first sample after reset fills the whole ring.
// ----------------------------------------------------------------------------
module averaged_temperature_sensor_core import avgts_pkg::*; #(
  parameter int unsigned TAPS = 10
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  avgts_in_if.sink          in_i,
  avgts_out_if.source       out_o
);

  localparam int unsigned SUM_W = $clog2(TAPS * SAMPLE_MAX + 1);

  state_e              state_q, state_d;
  step_t               step;
  logic [CAL_W-1:0]    cal_q;
  logic [DEG_W-1:0]    deg_q;
  logic [SAMPLE_W-1:0] sample_q, pot_q;
  logic [SUM_W-1:0]    sum;
  result_t             res;
  logic                in_fire, push, cfg_wr;
  reg_idx_e            reg_idx;
  logic                out_valid_q;
  result_t             out_res_q;
  logic [SAMPLE_W-1:0] out_pot_q;

  // Configuration port
  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    unique case (reg_idx)
      REG_CAL_OFFSET:    prdata = 32'(cal_q);
      REG_DEG_PER_COUNT: prdata = 32'(deg_q);
      default:           prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_q <= CAL_OFFSET_RST;
      deg_q <= DEG_PER_CNT_RST;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_CAL_OFFSET:    cal_q <= pwdata[CAL_W-1:0];
        REG_DEG_PER_COUNT: deg_q <= pwdata[DEG_W-1:0];
        default: ;
      endcase
    end
  end

  // Step sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (in_i.valid) state_d = S_RD;
      S_RD:    state_d = S_UPD;
      S_UPD:   state_d = S_DIVM;
      S_DIVM:  state_d = S_DIVC;
      S_DIVC:  state_d = S_MUL;
      S_MUL:   state_d = S_FMUL;
      S_FMUL:  state_d = S_FCOR;
      S_FCOR:  state_d = S_PUSH;
      S_PUSH:  if (!out_valid_q || out_o.ready) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    step       = '0;
    in_i.ready = 1'b0;
    push       = 1'b0;
    unique case (state_q)
      S_IDLE:  in_i.ready = 1'b1;
      S_RD:    step.rd = 1'b1;
      S_UPD:   step.upd = 1'b1;
      S_DIVM:  step.divm = 1'b1;
      S_DIVC:  step.divc = 1'b1;
      S_MUL:   step.mul = 1'b1;
      S_FMUL:  step.fmul = 1'b1;
      S_FCOR:  step.fcor = 1'b1;
      S_PUSH:  push = !out_valid_q || out_o.ready;
      default: ;
    endcase
  end

  assign in_fire = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      sample_q <= in_i.temp_sample;
      pot_q    <= in_i.pot_sample;
    end
  end

  avgts_ring #(.TAPS(TAPS)) u_ring (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .sample_i (sample_q),
    .sum_o    (sum)
  );

  avgts_calib #(.TAPS(TAPS)) u_calib (
    .clk_i           (clk_i),
    .step_i          (step),
    .sum_i           (sum),
    .cal_offset_i    (cal_q),
    .deg_per_count_i (deg_q),
    .res_o           (res)
  );

  // Output register: holds a beat while the next item is taken in
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (push) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      out_res_q <= res;
      out_pot_q <= pot_q;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.average_count = out_res_q.avg;
  assign out_o.temp_c_q8     = out_res_q.temp_c;
  assign out_o.temp_f_q8     = out_res_q.temp_f;
  assign out_o.pot_value     = out_pot_q;

`ifndef ASSERT_OFF
  a_fire_starts_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (state_q == S_RD))
    else $error("accepted beat did not start a ring read");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PUSH && out_valid_q && !out_o.ready) |=> (state_q == S_PUSH))
    else $error("result left push state while output was stalled");

  a_push_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |=> out_valid_q)
    else $error("pushed result not presented");

  a_ready_idle_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.ready |-> (state_q == S_IDLE && step == '0))
    else $error("input ready while an item is in flight");
`endif

endmodule
